FILE: rtl/lfug_pkg.sv
// shared constants and types for the lagged fibonacci uniform generator
package lfug_pkg;

  // table geometry and fraction width
  localparam int unsigned FracBits   = 24;
  localparam int unsigned TableDepth = 97;
  localparam int unsigned AddrW      = $clog2(TableDepth);

  // seed handling
  localparam int unsigned SeedW  = 30;
  localparam int unsigned DigitW = 8;
  localparam logic [SeedW-1:0]  SeedMin   = 30'd2;
  localparam logic [SeedW-1:0]  SeedMax   = 30'd796594177;
  localparam logic [DigitW:0]   DigitBase = 9'd168;

  // digit split: 168 = 21 x 8, the divide by 21 uses a reciprocal scaled by 2^32
  localparam logic [4:0]  BaseOdd        = 5'd21;
  localparam logic [27:0] BaseOddRecip   = 28'd204522252;
  localparam int unsigned BaseRecipShift = 32;

  // congruential fill generators, with reciprocals scaled by 2^16
  localparam logic [DigitW:0] ModA   = 9'd179;
  localparam logic [DigitW:0] ModD   = 9'd169;
  localparam logic [DigitW:0] RecipA = 9'd366;
  localparam logic [DigitW:0] RecipD = 9'd387;
  localparam logic [5:0]      DMul   = 6'd53;
  localparam int unsigned     RecipShift = 16;

  // carry sequence
  localparam logic [FracBits-1:0] CarryInit = 24'd362436;
  localparam logic [FracBits-1:0] CarryStep = 24'd7654321;
  // modulus minus step, added when the carry would go negative
  localparam logic [FracBits-1:0] CarryWrap = 24'd9122892;

  // lag slots after seeding (lag index minus one)
  localparam logic [AddrW-1:0] LongLagSlot  = AddrW'(TableDepth - 1);
  localparam logic [AddrW-1:0] ShortLagSlot = AddrW'(32);

  typedef enum logic {
    OpSeed = 1'b0,
    OpDraw = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusUnseeded = 2'd1,
    StatusBadSeed  = 2'd2
  } status_e;

endpackage

FILE: rtl/lfug_if.sv
// request and result channel interfaces of the generator

interface lfug_in_if;
  logic                       valid;
  logic                       ready;
  lfug_pkg::op_e              op;
  logic [lfug_pkg::SeedW-1:0] seed;

  modport source (output valid, output op, output seed, input ready);
  modport sink   (input valid, input op, input seed, output ready);
endinterface

interface lfug_out_if;
  logic                          valid;
  logic                          ready;
  logic [lfug_pkg::FracBits-1:0] value;
  lfug_pkg::status_e             status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

FILE: rtl/lfug_ram.sv
// generic ram: one write port, two registered read ports
module lfug_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 97
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: rtl/lagged_fibonacci_uniform_generator.sv
// lagged fibonacci uniform generator top level: table ram, seed unit and draw path
//
//  channel  | dir | transfer on        | payload
//  ---------+-----+--------------------+---------------------------------
//  in_i     | in  | valid && ready     | op (seed/draw), seed[29:0]
//  out_o    | out | valid && ready     | value[23:0], status[1:0]
//
// a draw reads the table at acceptance, then subtracts and writes back
// into the single table ram in the next cycle. a seed runs the base-168
// digit split, one check, then 97 x 24 fill steps through the shared
// mod-179/169 datapath. a rejected range or an unseeded draw answers in
// the cycle after acceptance, all-one digits after the split and check.
// after reset the table is unwritten and draws are flagged until a good
// seed; there is no clearing pass. a stalled result holds in the output
// register and keeps ready low; one item is in flight at a time.
module lagged_fibonacci_uniform_generator (
  input logic        clk_i,
  input logic        rst_ni,
  lfug_in_if.sink    in_i,
  lfug_out_if.source out_o
);

  localparam int unsigned FracBits = lfug_pkg::FracBits;
  localparam int unsigned AddrW    = lfug_pkg::AddrW;
  localparam int unsigned SeedW    = lfug_pkg::SeedW;
  localparam int unsigned DigitW   = lfug_pkg::DigitW;

  // controller states
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDraw   = 3'd1;
  localparam logic [2:0] StDivide = 3'd2;
  localparam logic [2:0] StCheck  = 3'd3;
  localparam logic [2:0] StFill   = 3'd4;

  // fill step phases
  localparam logic [2:0] PhMulA  = 3'd0;
  localparam logic [2:0] PhQuoA  = 3'd1;
  localparam logic [2:0] PhRemA  = 3'd2;
  localparam logic [2:0] PhMulC  = 3'd3;
  localparam logic [2:0] PhQuoC  = 3'd4;
  localparam logic [2:0] PhRemC  = 3'd5;
  localparam logic [2:0] PhShift = 3'd6;

  // control state
  logic [2:0]          state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                seeded_q, seeded_d;
  logic [FracBits-1:0] carry_q, carry_d;
  logic [AddrW-1:0]    long_q, long_d;
  logic [AddrW-1:0]    short_q, short_d;
  logic [4:0]          bit_q, bit_d;
  logic [1:0]          dig_q, dig_d;
  logic [2:0]          phase_q, phase_d;
  logic [AddrW-1:0]    word_q, word_d;

  // payload and datapath registers
  logic [FracBits-1:0]      value_q, value_d;
  lfug_pkg::status_e        status_q, status_d;
  logic [SeedW-1:0]         rest_q, rest_d;
  logic [SeedW-1:0]         quot_q, quot_d;
  logic [DigitW-1:0]        a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [15:0]              prod_q, prod_d;
  logic [DigitW-1:0]        quo_q, quo_d;
  logic [DigitW:0]          red_q, red_d;
  logic [13:0]              dprod_q, dprod_d;
  logic [DigitW-1:0]        dquo_q, dquo_d;
  logic [DigitW:0]          dred_q, dred_d;
  logic [FracBits-2:0]      acc_q, acc_d;

  // handshake
  logic in_xfer, out_xfer;

  // table ram ports
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [FracBits-1:0] ram_wdata;
  logic [FracBits-1:0] rd_long, rd_short;

  // datapath helpers
  logic [SeedW-4:0]    div_x;
  logic [SeedW-1:0]    quot_next, quot_fix;
  logic [5:0]          part_rem;
  logic                part_geq;
  logic [4:0]          part_fix;
  logic [DigitW-1:0]   digit, digit_p1;
  logic [DigitW-1:0]   quo_next, dquo_next;
  logic [DigitW:0]     red_calc, dred_calc;
  logic [DigitW-1:0]   red_fix, dred_fix;
  logic [11:0]         dm_prod;
  logic                fill_bit;
  logic [FracBits-1:0] draw_x, carry_next;
  logic                seed_bad_range, digits_all_one;

  assign in_i.ready = (state_q == StIdle) && (!out_valid_q || out_o.ready);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = value_q;
  assign out_o.status = status_q;

  // lag table
  lfug_ram #(
    .Width (FracBits),
    .Depth (lfug_pkg::TableDepth)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (long_q),
    .raddr_b_i (short_q),
    .rdata_a_o (rd_long),
    .rdata_b_o (rd_short)
  );

  // divide by 168: drop three bits, then reciprocal multiply by 1/21 and one correction
  assign div_x     = rest_q[SeedW-1:3];
  assign quot_next = SeedW'((56'(div_x) * 56'(lfug_pkg::BaseOddRecip))
                            >> lfug_pkg::BaseRecipShift);
  assign part_rem  = 6'(div_x - (SeedW-3)'(quot_q) * (SeedW-3)'(lfug_pkg::BaseOdd));
  assign part_geq  = part_rem >= 6'(lfug_pkg::BaseOdd);
  assign part_fix  = 5'(part_geq ? part_rem - 6'(lfug_pkg::BaseOdd) : part_rem);
  assign quot_fix  = part_geq ? quot_q + SeedW'(1) : quot_q;
  assign digit     = {part_fix, rest_q[2:0]};
  assign digit_p1  = digit + DigitW'(1);

  // modular reduction by reciprocal multiply and one correction
  assign quo_next  = DigitW'((24'(prod_q) * 24'(lfug_pkg::RecipA)) >> lfug_pkg::RecipShift);
  assign red_calc  = (DigitW+1)'(prod_q - 16'(quo_q) * 16'(lfug_pkg::ModA));
  assign red_fix   = DigitW'((red_q >= lfug_pkg::ModA) ? red_q - lfug_pkg::ModA : red_q);
  assign dquo_next = DigitW'((24'(dprod_q) * 24'(lfug_pkg::RecipD)) >> lfug_pkg::RecipShift);
  assign dred_calc = (DigitW+1)'(dprod_q - 14'(dquo_q) * 14'(lfug_pkg::ModD));
  assign dred_fix  = DigitW'((dred_q >= lfug_pkg::ModD) ? dred_q - lfug_pkg::ModD : dred_q);

  // output bit: bit 5 of d * m, only the low six bits of each matter
  assign dm_prod  = 12'(d_q[5:0]) * 12'(red_fix[5:0]);
  assign fill_bit = dm_prod[5];

  // draw arithmetic
  assign draw_x     = rd_long - rd_short;
  assign carry_next = (carry_q >= lfug_pkg::CarryStep) ? carry_q - lfug_pkg::CarryStep
                                                        : carry_q + lfug_pkg::CarryWrap;

  assign seed_bad_range = (in_i.seed < lfug_pkg::SeedMin) || (in_i.seed > lfug_pkg::SeedMax);
  assign digits_all_one = (a_q == DigitW'(1)) && (b_q == DigitW'(1)) &&
                          (c_q == DigitW'(1)) && (d_q == DigitW'(1));

  // controller and datapath next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_xfer;
    seeded_d    = seeded_q;
    carry_d     = carry_q;
    long_d      = long_q;
    short_d     = short_q;
    bit_d       = bit_q;
    dig_d       = dig_q;
    phase_d     = phase_q;
    word_d      = word_q;
    value_d     = value_q;
    status_d    = status_q;
    rest_d      = rest_q;
    quot_d      = quot_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    prod_d      = prod_q;
    quo_d       = quo_q;
    red_d       = red_q;
    dprod_d     = dprod_q;
    dquo_d      = dquo_q;
    dred_d      = dred_q;
    acc_d       = acc_q;
    ram_we      = 1'b0;
    ram_waddr   = long_q;
    ram_wdata   = draw_x;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_i.op == lfug_pkg::OpDraw) begin
            if (seeded_q) begin
              state_d = StDraw;
            end else begin
              out_valid_d = 1'b1;
              value_d     = '0;
              status_d    = lfug_pkg::StatusUnseeded;
            end
          end else if (seed_bad_range) begin
            out_valid_d = 1'b1;
            value_d     = '0;
            status_d    = lfug_pkg::StatusBadSeed;
          end else begin
            rest_d  = in_i.seed - SeedW'(1);
            bit_d   = '0;
            dig_d   = '0;
            state_d = StDivide;
          end
        end
      end

      // read data is back: subtract, write back, step lags and carry
      StDraw: begin
        ram_we      = 1'b1;
        carry_d     = carry_next;
        long_d      = (long_q == '0) ? lfug_pkg::LongLagSlot : long_q - AddrW'(1);
        short_d     = (short_q == '0) ? lfug_pkg::LongLagSlot : short_q - AddrW'(1);
        out_valid_d = 1'b1;
        value_d     = draw_x - carry_next;
        status_d    = lfug_pkg::StatusOk;
        state_d     = StIdle;
      end

      // split seed-1 into four base-168 digits, low digit first, a quotient step then a correction step a digit
      StDivide: begin
        if (!bit_q[0]) begin
          quot_d = quot_next;
          bit_d  = 5'd1;
        end else begin
          rest_d = quot_fix;
          bit_d  = '0;
          dig_d  = dig_q + 2'd1;
          unique case (dig_q)
            2'd0: a_d = digit;
            2'd1: b_d = digit_p1;
            2'd2: c_d = digit_p1;
            2'd3: begin
              d_d     = digit_p1;
              state_d = StCheck;
            end
          endcase
        end
      end

      StCheck: begin
        if (digits_all_one) begin
          out_valid_d = 1'b1;
          value_d     = '0;
          status_d    = lfug_pkg::StatusBadSeed;
          state_d     = StIdle;
        end else begin
          phase_d = PhMulA;
          bit_d   = '0;
          word_d  = '0;
          state_d = StFill;
        end
      end

      // a generator step is the mul, quo, rem phases for a and c plus a shift; 24 steps per table word
      StFill: begin
        unique case (phase_q)
          PhMulA: begin
            prod_d  = 16'(a_q) * 16'(b_q);
            dprod_d = 14'(lfug_pkg::DMul) * 14'(d_q) + 14'd1;
            phase_d = PhQuoA;
          end
          PhQuoA, PhQuoC: begin
            quo_d   = quo_next;
            dquo_d  = dquo_next;
            phase_d = phase_q + 3'd1;
          end
          PhRemA, PhRemC: begin
            red_d   = red_calc;
            dred_d  = dred_calc;
            phase_d = phase_q + 3'd1;
          end
          PhMulC: begin
            prod_d  = 16'(red_fix) * 16'(c_q);
            d_d     = dred_fix;
            phase_d = PhQuoC;
          end
          PhShift: begin
            a_d     = b_q;
            b_d     = c_q;
            c_d     = red_fix;
            acc_d   = {acc_q[FracBits-3:0], fill_bit};
            bit_d   = bit_q + 5'd1;
            phase_d = PhMulA;
            if (bit_q == 5'(FracBits - 1)) begin
              bit_d     = '0;
              ram_we    = 1'b1;
              ram_waddr = word_q;
              ram_wdata = {acc_q, fill_bit};
              word_d    = word_q + AddrW'(1);
              if (word_q == AddrW'(lfug_pkg::TableDepth - 1)) begin
                carry_d     = lfug_pkg::CarryInit;
                long_d      = lfug_pkg::LongLagSlot;
                short_d     = lfug_pkg::ShortLagSlot;
                seeded_d    = 1'b1;
                out_valid_d = 1'b1;
                value_d     = '0;
                status_d    = lfug_pkg::StatusOk;
                state_d     = StIdle;
              end
            end
          end
          default: phase_d = PhMulA;
        endcase
      end

      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      seeded_q    <= 1'b0;
      carry_q     <= '0;
      long_q      <= lfug_pkg::LongLagSlot;
      short_q     <= lfug_pkg::ShortLagSlot;
      bit_q       <= '0;
      dig_q       <= '0;
      phase_q     <= PhMulA;
      word_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      seeded_q    <= seeded_d;
      carry_q     <= carry_d;
      long_q      <= long_d;
      short_q     <= short_d;
      bit_q       <= bit_d;
      dig_q       <= dig_d;
      phase_q     <= phase_d;
      word_q      <= word_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    rest_q   <= rest_d;
    quot_q   <= quot_d;
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    d_q      <= d_d;
    prod_q   <= prod_d;
    quo_q    <= quo_d;
    red_q    <= red_d;
    dprod_q  <= dprod_d;
    dquo_q   <= dquo_d;
    dred_q   <= dred_d;
    acc_q    <= acc_d;
  end

endmodule

FILE: rtl/lfug_checker.sv
// port-level checks for the generator, bound to the top level
module lfug_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input lfug_pkg::op_e                 in_op_i,
  input logic [lfug_pkg::SeedW-1:0]    in_seed_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [lfug_pkg::FracBits-1:0] out_value_i,
  input lfug_pkg::status_e             out_status_i
);

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_status_i))
    else $error("stalled result changed");

  // no new request is taken while a result is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("request taken while result stalled");

  // an out-of-range seed is rejected on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == lfug_pkg::OpSeed) &&
    ((in_seed_i < lfug_pkg::SeedMin) || (in_seed_i > lfug_pkg::SeedMax))
    |=> out_valid_i && (out_status_i == lfug_pkg::StatusBadSeed))
    else $error("out-of-range seed not rejected");

  // flagged results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != lfug_pkg::StatusOk) |-> out_value_i == '0)
    else $error("flagged result with non-zero value");

endmodule

bind lagged_fibonacci_uniform_generator lfug_checker u_lfug_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .in_seed_i    (in_i.seed),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_value_i  (out_o.value),
  .out_status_i (out_o.status)
);

FILE: bench/lagged_fibonacci_uniform_generator_test.sv
`timescale 1ns / 100ps
// self-checking bench for the lagged fibonacci uniform generator: seeding, draws and rejects
module lagged_fibonacci_uniform_generator_test;

  localparam int unsigned FracBits     = lfug_pkg::FracBits;
  localparam int unsigned SeedW        = lfug_pkg::SeedW;
  localparam int unsigned TableDepth   = lfug_pkg::TableDepth;
  localparam logic [SeedW-1:0] SeedTop = '1;
  localparam int unsigned StimItems    = 1500;
  localparam int unsigned QuietItems   = 200;
  localparam int unsigned MaxRandSeeds = 12;
  localparam int unsigned HoldAt       = 600;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned CycleLimit   = 1_200_000;
  localparam int unsigned BitMod       = 64;
  localparam int unsigned BitHalf      = 32;
  localparam int unsigned MaxPrinted   = 40;

  typedef struct packed {
    logic [FracBits-1:0] value;
    lfug_pkg::status_e   status;
  } fraction_t;

  // predicted generator state and the results still owed by the block
  class fraction_scoreboard;
    logic [FracBits-1:0] lag_q [TableDepth];
    logic [FracBits-1:0] carry;
    int unsigned         long_idx;
    int unsigned         short_idx;
    bit                  seeded;
    fraction_t           expected_fractions [$];
    int unsigned         mismatches;
    int unsigned         results_seen;

    function new();
      foreach (lag_q[n]) lag_q[n] = '0;
      carry        = '0;
      long_idx     = TableDepth;
      short_idx    = lfug_pkg::ShortLagSlot + 1;
      seeded       = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // split the seed into base-168 digits and fill the table bit by bit
    function bit fill_table(logic [SeedW-1:0] s);
      int unsigned         rest, a, b, c, d, m, n, k;
      logic [FracBits-1:0] acc;
      if (s < lfug_pkg::SeedMin || s > lfug_pkg::SeedMax) return 1'b0;
      rest = s - 1;
      a    = rest % lfug_pkg::DigitBase;
      rest = rest / lfug_pkg::DigitBase;
      b    = rest % lfug_pkg::DigitBase + 1;
      rest = rest / lfug_pkg::DigitBase;
      c    = rest % lfug_pkg::DigitBase + 1;
      rest = rest / lfug_pkg::DigitBase;
      d    = rest % lfug_pkg::DigitBase + 1;
      if (a == 1 && b == 1 && c == 1 && d == 1) return 1'b0;
      for (n = 0; n < TableDepth; n++) begin
        acc = '0;
        for (k = 0; k < FracBits; k++) begin
          m = (((a * b) % lfug_pkg::ModA) * c) % lfug_pkg::ModA;
          a = b;
          b = c;
          c = m;
          d = (lfug_pkg::DMul * d + 1) % lfug_pkg::ModD;
          if ((d * m) % BitMod >= BitHalf) acc[FracBits-1-k] = 1'b1;
        end
        lag_q[n] = acc;
      end
      carry     = lfug_pkg::CarryInit;
      long_idx  = TableDepth;
      short_idx = lfug_pkg::ShortLagSlot + 1;
      seeded    = 1'b1;
      return 1'b1;
    endfunction

    // subtractive lag step, then remove the carry sequence
    function logic [FracBits-1:0] next_fraction();
      logic [FracBits-1:0] x;
      x = lag_q[long_idx-1] - lag_q[short_idx-1];
      lag_q[long_idx-1] = x;
      long_idx  = (long_idx <= 1) ? TableDepth : long_idx - 1;
      short_idx = (short_idx <= 1) ? TableDepth : short_idx - 1;
      if (carry >= lfug_pkg::CarryStep) carry = carry - lfug_pkg::CarryStep;
      else carry = carry + lfug_pkg::CarryWrap;
      return x - carry;
    endfunction

    // accepted request: work out the one result it owes
    function void note_request(lfug_pkg::op_e op, logic [SeedW-1:0] s);
      fraction_t r;
      r.value  = '0;
      r.status = lfug_pkg::StatusOk;
      if (op == lfug_pkg::OpSeed) begin
        if (!fill_table(s)) r.status = lfug_pkg::StatusBadSeed;
      end else if (!seeded) begin
        r.status = lfug_pkg::StatusUnseeded;
      end else begin
        r.value = next_fraction();
      end
      expected_fractions.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MaxPrinted) $display("result %0d: %s", results_seen, msg);
    endtask

    // accepted result against the oldest prediction
    task check_result(logic [FracBits-1:0] value, lfug_pkg::status_e status);
      fraction_t r;
      results_seen++;
      if (expected_fractions.size() == 0) begin
        report($sformatf("unexpected transfer, value %0d status %0d", value, status));
        return;
      end
      r = expected_fractions.pop_front();
      if (value !== r.value)
        report($sformatf("value %0d, predicted %0d", value, r.value));
      if (status !== r.status)
        report($sformatf("status %0d, predicted %0d", status, r.status));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  bit          quiet = 1'b0;
  int unsigned cycles = 0;

  fraction_scoreboard board = new();

  lfug_in_if  in_bus ();
  lfug_out_if out_bus ();

  lagged_fibonacci_uniform_generator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("lagged_fibonacci_uniform_generator: mismatch");
      $finish;
    end
  end

  // offer one request, with an occasional gap first; returns on a falling edge
  task automatic send_item(lfug_pkg::op_e op, logic [SeedW-1:0] s);
    if (!quiet && $urandom_range(3, 0) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.op    <= op;
    in_bus.seed  <= s;
    do @(posedge clk_i); while (!in_bus.ready);
    board.note_request(op, s);
    @(negedge clk_i);
  endtask

  // result side: random stalls, one long hold-off, check on each transfer
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    bit          held;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && board.results_seen >= HoldAt) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(4, 0) == 0) begin
        stall_left = $urandom_range(8, 1) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready)
        board.check_result(out_bus.value, out_bus.status);
    end
  end

  // request side
  initial begin : stimulus
    int unsigned      roll;
    int unsigned      rand_seeds;
    int unsigned      i;
    logic [SeedW-1:0] s;
    rst_ni = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.op    <= lfug_pkg::OpDraw;
    in_bus.seed  <= '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // draws before any seed, and every kind of rejected seed
    send_item(lfug_pkg::OpDraw, '0);
    send_item(lfug_pkg::OpDraw, SeedTop);
    send_item(lfug_pkg::OpSeed, '0);
    send_item(lfug_pkg::OpSeed, 30'd1);
    // smallest in range, but its digits are all one
    send_item(lfug_pkg::OpSeed, lfug_pkg::SeedMin);
    send_item(lfug_pkg::OpSeed, lfug_pkg::SeedMax + SeedW'(1));
    send_item(lfug_pkg::OpSeed, SeedTop);
    send_item(lfug_pkg::OpDraw, 30'h2AAA_AAAA);
    // smallest and largest good seeds
    send_item(lfug_pkg::OpSeed, 30'd3);
    repeat (4) send_item(lfug_pkg::OpDraw, SeedW'($urandom));
    send_item(lfug_pkg::OpSeed, lfug_pkg::SeedMax);
    repeat (4) send_item(lfug_pkg::OpDraw, SeedW'($urandom));
    // a reject after seeding must leave the sequence alone
    send_item(lfug_pkg::OpSeed, 30'd1);
    repeat (2) send_item(lfug_pkg::OpDraw, SeedW'($urandom));
    send_item(lfug_pkg::OpSeed, 30'd54217);
    repeat (2) send_item(lfug_pkg::OpDraw, SeedW'($urandom));

    // mostly draws, rare reseeds, some rejected seeds across all 30 bits
    rand_seeds = 0;
    for (i = 0; i < StimItems; i++) begin
      quiet = (i >= StimItems - QuietItems);
      roll  = $urandom_range(999, 0);
      if (roll < 8 && rand_seeds < MaxRandSeeds) begin
        rand_seeds++;
        send_item(lfug_pkg::OpSeed,
                  SeedW'($urandom_range(32'(lfug_pkg::SeedMax), 3)));
      end else if (roll < 50) begin
        if ($urandom_range(3, 0) == 0) s = SeedW'($urandom_range(2, 0));
        else s = SeedW'($urandom_range(32'(SeedTop), 32'(lfug_pkg::SeedMax) + 32'd1));
        send_item(lfug_pkg::OpSeed, s);
      end else begin
        send_item(lfug_pkg::OpDraw, SeedW'($urandom));
      end
    end

    // drain
    in_bus.valid <= 1'b0;
    while (board.expected_fractions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_fractions.size() == 0) begin
      $display("lagged_fibonacci_uniform_generator: match");
    end else begin
      $display("lagged_fibonacci_uniform_generator: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lfug_pkg.sv
rtl/lfug_if.sv
rtl/lfug_ram.sv
rtl/lagged_fibonacci_uniform_generator.sv
rtl/lfug_checker.sv
bench/lagged_fibonacci_uniform_generator_test.sv
